// ===== src/sha_pkg.sv =====
package sha_pkg;

	localparam int unsigned NumRounds = 64;
	localparam int unsigned NumHash   = 8;

	typedef logic [31:0] word_t;
	typedef word_t [0:NumHash-1] hash_t;
	typedef logic [$clog2(NumRounds)-1:0] round_t;

	// sequencer -> round unit
	typedef struct packed {
		logic  push;
		logic  start;
		word_t word;
	} sha_ctl_t;

	// round unit -> sequencer
	typedef struct packed {
		logic  done;
		hash_t vars;
	} sha_sts_t;

	localparam hash_t H_INIT = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t ROUND_K [NumRounds] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

endpackage

// ===== src/sha_in_if.sv =====
interface sha_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last_word;

	modport source (output valid, output data_word, output valid_bytes, output last_word,
		input ready);
	modport sink (input valid, input data_word, input valid_bytes, input last_word,
		output ready);
endinterface

// ===== src/sha_out_if.sv =====
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	modport source (output valid, output digest_word, output digest_index,
		output digest_last, input ready);
	modport sink (input valid, input digest_word, input digest_index,
		input digest_last, output ready);
endinterface

// ===== src/sha_core.sv =====
module sha_core
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sha_ctl_t ctl,
	input  hash_t    hash_in,
	output sha_sts_t sts
);

	word_t  w_q [16];
	hash_t  v_q;
	round_t rnd_q;
	logic   run_q;
	logic   done_q;

	word_t  w_next;
	word_t  t1;
	word_t  t2;

	function automatic word_t sig0(input word_t x);
		sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// window holds W[t] .. W[t+15] while running
	assign w_next = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + w_q[0];
	assign t2 = bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == round_t'(NumRounds - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push || run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= run_q ? w_next : ctl.word;
		end
		if (ctl.start) begin
			v_q <= hash_in;
		end else if (run_q) begin
			v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
		end
	end

	assign sts.done = done_q;
	assign sts.vars = v_q;

endmodule

// ===== src/sha256_hash_engine.sv =====
// Channel  Dir  Payload                                   Transaction
// msg      in   data_word, valid_bytes, last_word         one message word
// dig      out  digest_word, digest_index, digest_last    one digest word
//
// The 16th accepted word of a block starts 64 rounds on the single round
// unit, and the result of those rounds is then folded into the hash.
// The last word adds one padding word per cycle up to the block end (one or
// two more blocks), then eight digest transactions, one per cycle when taken.
// msg.ready is low while a block compresses and from the last word until the
// digest is out.
// arst_n clears the sequencer, bit count and hash to the initial values.
module sha256_hash_engine
	import sha_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sha_in_if.sink        msg,
	sha_out_if.source     dig
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FILL = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t      state_q;
	hash_t       hash_q;
	logic [63:0] bits_q;
	logic [3:0]  slot_q;
	logic [2:0]  idx_q;
	logic        final_q;
	logic        pad_q;
	logic        len_q;
	logic        fin_q;

	sha_ctl_t    ctl;
	sha_sts_t    sts;
	logic        acc;
	logic        out_acc;
	logic [2:0]  nvalid;
	word_t       pad_word;

	assign msg.ready = (state_q == ST_IDLE);
	assign acc       = msg.valid && msg.ready;
	assign dig.valid = (state_q == ST_OUT);
	assign out_acc   = dig.valid && dig.ready;

	assign dig.digest_word  = hash_q[idx_q];
	assign dig.digest_index = idx_q;
	assign dig.digest_last  = (idx_q == 3'd7);

	assign nvalid = (!msg.last_word || msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;

	always_comb begin
		case (nvalid)
			3'd0:    pad_word = 32'h8000_0000;
			3'd1:    pad_word = {msg.data_word[31:24], 24'h80_0000};
			3'd2:    pad_word = {msg.data_word[31:16], 16'h8000};
			3'd3:    pad_word = {msg.data_word[31:8], 8'h80};
			default: pad_word = msg.data_word;
		endcase
	end

	always_comb begin
		ctl.push = 1'b0;
		ctl.word = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.push = acc;
				ctl.word = pad_word;
			end
			ST_FILL: begin
				ctl.push = 1'b1;
				if (pad_q) begin
					ctl.word = 32'h8000_0000;
				end else if (slot_q == 4'd14) begin
					ctl.word = bits_q[63:32];
				end else if (slot_q == 4'd15 && len_q) begin
					ctl.word = bits_q[31:0];
				end
			end
			ST_COMP, ST_OUT: begin
				ctl.push = 1'b0;
			end
			default: begin
				ctl.push = 1'b0;
			end
		endcase
		ctl.start = ctl.push && (slot_q == 4'd15);
	end

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.hash_in (hash_q),
		.sts     (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q  <= H_INIT;
			bits_q  <= '0;
			slot_q  <= '0;
			idx_q   <= '0;
			final_q <= 1'b0;
			pad_q   <= 1'b0;
			len_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (ctl.push) begin
				slot_q <= slot_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						bits_q <= bits_q + {58'd0, nvalid, 3'd0};
						if (msg.last_word) begin
							final_q <= 1'b1;
							pad_q   <= (nvalid == 3'd4);
						end
						if (slot_q == 4'd15) begin
							state_q <= ST_COMP;
						end else if (msg.last_word) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					pad_q <= 1'b0;
					if (!pad_q && slot_q == 4'd14) begin
						len_q <= 1'b1;
					end
					if (slot_q == 4'd15) begin
						if (len_q) begin
							fin_q <= 1'b1;
						end
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (sts.done) begin
						for (int i = 0; i < NumHash; i++) begin
							hash_q[i] <= hash_q[i] + sts.vars[i];
						end
						if (fin_q) begin
							state_q <= ST_OUT;
						end else if (final_q) begin
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							hash_q  <= H_INIT;
							bits_q  <= '0;
							final_q <= 1'b0;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> slot_q == 4'd0)
		else $error("digest shown with a partial block");

	a_done_comp: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == ST_COMP)
		else $error("round unit finished outside compression");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && slot_q == 4'd15) |=> state_q == ST_COMP)
		else $error("full block did not start compression");

	a_msg_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && dig.digest_last) |=> (state_q == ST_IDLE && bits_q == 64'd0))
		else $error("engine not cleared after digest");
`endif

endmodule
